// ===== src/vdd_pkg.sv =====
// Package for the vector dot / distance unit.
// Holds operation codes, item kinds, shared widths, the control struct and the square root status struct.
// Used by every module in src but vdd_queue; depends on nothing else.
`default_nettype none

package vdd_pkg;

  // Default element width (Q8.8) and fixed port widths.
  localparam int unsigned ELEM_BITS_DEF = 16;
  localparam int unsigned IN_W          = 16;
  localparam int unsigned ACC_W         = 44;
  localparam int unsigned ROOT_W        = ACC_W / 2;

  // Operation codes of the op field.
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_DOT    = 3'd2,
    OP_NORM   = 3'd3,
    OP_DIST   = 3'd4,
    OP_SQDIST = 3'd5
  } op_e;

  // What the back end does with a queued item.
  typedef enum logic [1:0] {
    KIND_ELEM  = 2'd0,
    KIND_TOTAL = 2'd1,
    KIND_ROOT  = 2'd2
  } kind_e;

  // Control part of a queued item.
  typedef struct packed {
    kind_e kind;
    logic  last;
  } ctrl_t;

  // Status of the square root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

// ===== src/vector_dot_distance_unit.sv =====
// Vector dot product and Euclidean distance unit.
// Streams element pairs (a, b) in signed Q8.8 on a valid/ready input channel.
// Add and sub return one result per item; dot, norm, distance and squared
// distance accumulate into a saturating 44-bit accumulator and return one
// total on the item marked last (the Q14.8 floor root for norm and distance).
// Results leave on a valid/ready output channel with an is_total flag.
// Throughput: one item per cycle while accumulating. An element result
// passes the queue, the product stage and the output register; a dot or
// squared distance total likewise. A root then passes the one-bit-per-cycle
// square root unit and moves into the output register. The next vector keeps
// accumulating meanwhile, but any later result waits for that root to leave.
// A two-entry queue separates input from the multiplier.
// Reset clears the accumulator, the queue and all valid flags. When the
// receiver stalls, the output holds and the queue fills, then input ready
// drops. Ops 6 and 7 are taken and dropped.
// Depends on vdd_pkg, vdd_front, vdd_queue, vdd_back and vdd_sqrt.
`default_nettype none

module vector_dot_distance_unit #(
  parameter int unsigned ELEM_BITS = vdd_pkg::ELEM_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [2:0]                op_i,
  input  wire logic [vdd_pkg::IN_W-1:0]  a_element_i,
  input  wire logic [vdd_pkg::IN_W-1:0]  b_element_i,
  input  wire logic                      last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [vdd_pkg::ACC_W-1:0]      value_o,
  output logic                           is_total_o
);
  import vdd_pkg::*;

  localparam int unsigned XW = ELEM_BITS + 1;
  localparam int unsigned QW = $bits(ctrl_t) + 2 * XW;

  logic                 push;
  logic                 q_ready;
  logic                 q_valid;
  logic                 q_pop;
  ctrl_t                f_ctrl;
  logic signed [XW-1:0] f_x;
  logic signed [XW-1:0] f_y;
  logic [QW-1:0]        q_in;
  logic [QW-1:0]        q_out;
  ctrl_t                b_ctrl;
  logic signed [XW-1:0] b_x;
  logic signed [XW-1:0] b_y;

  vdd_front #(
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .a_element_i (a_element_i),
    .b_element_i (b_element_i),
    .last_i      (last_i),
    .push_o      (push),
    .q_ready_i   (q_ready),
    .ctrl_o      (f_ctrl),
    .x_o         (f_x),
    .y_o         (f_y)
  );

  // Pack and unpack queue entries.
  assign q_in = {f_ctrl, f_x, f_y};
  assign {b_ctrl, b_x, b_y} = q_out;

  vdd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_out)
  );

  vdd_back #(
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_ctrl_i    (b_ctrl),
    .q_x_i       (b_x),
    .q_y_i       (b_y),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .is_total_o  (is_total_o)
  );

endmodule

`default_nettype wire

// ===== src/vdd_front.sv =====
// Front end of the vector dot / distance unit.
// Accepts input items, classifies the op and forms the multiplier operands.
// Depends on vdd_pkg.
`default_nettype none

module vdd_front #(
  parameter int unsigned ELEM_BITS = vdd_pkg::ELEM_BITS_DEF
) (
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [2:0]                 op_i,
  input  wire logic [vdd_pkg::IN_W-1:0]   a_element_i,
  input  wire logic [vdd_pkg::IN_W-1:0]   b_element_i,
  input  wire logic                       last_i,
  output logic                            push_o,
  input  wire logic                       q_ready_i,
  output vdd_pkg::ctrl_t                  ctrl_o,
  output logic signed [ELEM_BITS:0]       x_o,
  output logic signed [ELEM_BITS:0]       y_o
);
  import vdd_pkg::*;

  localparam int unsigned XW = ELEM_BITS + 1;

  logic signed [ELEM_BITS-1:0] a_s;
  logic signed [ELEM_BITS-1:0] b_s;
  logic signed [XW-1:0]        a_x;
  logic signed [XW-1:0]        b_x;
  logic signed [XW-1:0]        diff;
  logic                        op_ok;

  // Take the low ELEM_BITS bits of each element as two's complement.
  assign a_s  = ELEM_BITS'({{ELEM_BITS{1'b0}}, a_element_i});
  assign b_s  = ELEM_BITS'({{ELEM_BITS{1'b0}}, b_element_i});
  assign a_x  = XW'(a_s);
  assign b_x  = XW'(b_s);
  assign diff = a_x - b_x;

  // The queue being able to take an item is the only thing that stalls input.
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && op_ok;

  // Classify the op; unused codes are taken and dropped.
  always_comb begin
    op_ok       = 1'b1;
    ctrl_o.kind = KIND_ELEM;
    ctrl_o.last = last_i;
    x_o         = a_x;
    y_o         = b_x;
    case (op_e'(op_i))
      OP_ADD: begin
        x_o = a_x + b_x;
      end
      OP_SUB: begin
        x_o = diff;
      end
      OP_DOT: begin
        ctrl_o.kind = KIND_TOTAL;
      end
      OP_NORM: begin
        ctrl_o.kind = KIND_ROOT;
        y_o         = a_x;
      end
      OP_DIST: begin
        ctrl_o.kind = KIND_ROOT;
        x_o         = diff;
        y_o         = diff;
      end
      OP_SQDIST: begin
        ctrl_o.kind = KIND_TOTAL;
        x_o         = diff;
        y_o         = diff;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/vdd_queue.sv =====
// Two-entry queue between the front and back ends.
// Generic payload of WIDTH bits; depends on nothing else.
`default_nettype none

module vdd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             wr_ptr_d;
  logic             rd_ptr_q;
  logic             rd_ptr_d;
  logic [1:0]       cnt_q;
  logic [1:0]       cnt_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/vdd_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Takes a 44-bit radicand and holds the 22-bit root until acknowledged.
// Depends on vdd_pkg.
`default_nettype none

module vdd_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [vdd_pkg::ACC_W-1:0]   radicand_i,
  input  wire logic                        ack_i,
  output vdd_pkg::sqrt_stat_t              stat_o,
  output logic [vdd_pkg::ROOT_W-1:0]       root_o
);
  import vdd_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic              busy_q;
  logic              busy_d;
  logic              done_q;
  logic              done_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_d;
  logic [ACC_W-1:0]  rad_q;
  logic [ACC_W-1:0]  rad_d;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W:0]   rem_d;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] root_d;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              ge;

  // One digit step: bring down two radicand bits and try the next root bit.
  assign rem_sh  = {rem_q, rad_q[ACC_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign ge      = (rem_sh >= trial);

  assign stat_o.busy = busy_q || done_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (busy_q) begin
      rad_d  = {rad_q[ACC_W-3:0], 2'b00};
      rem_d  = ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q) begin
      if (ack_i) begin
        done_d = 1'b0;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

`default_nettype wire

// ===== src/vdd_back.sv =====
// Back end of the vector dot / distance unit.
// Multiplies, accumulates with saturation, starts roots and drives the output.
// Depends on vdd_pkg and vdd_sqrt.
`default_nettype none

module vdd_back #(
  parameter int unsigned ELEM_BITS = vdd_pkg::ELEM_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  output logic                            q_pop_o,
  input  wire vdd_pkg::ctrl_t             q_ctrl_i,
  input  wire logic signed [ELEM_BITS:0]  q_x_i,
  input  wire logic signed [ELEM_BITS:0]  q_y_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [vdd_pkg::ACC_W-1:0]       value_o,
  output logic                            is_total_o
);
  import vdd_pkg::*;

  localparam int unsigned XW = ELEM_BITS + 1;
  localparam int unsigned PW = 2 * XW;
  localparam int unsigned SW = ((ACC_W > PW) ? ACC_W : PW) + 1;

  // Product stage.
  logic                 p_valid_q;
  ctrl_t                p_ctrl_q;
  logic signed [XW-1:0] p_x_q;
  logic signed [PW-1:0] p_prod_q;

  // Accumulator and output register.
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [ACC_W-1:0]        value_q;
  logic [ACC_W-1:0]        value_d;
  logic                    is_total_q;
  logic                    is_total_d;

  logic signed [SW-1:0]    sum;
  logic                    ovf;
  logic signed [ACC_W-1:0] sat;
  logic                    out_free;
  logic                    needs_out;
  logic                    p_go;
  logic                    sq_start;
  logic                    sq_ack;
  logic [ACC_W-1:0]        radicand;
  sqrt_stat_t              sq_stat;
  logic [ROOT_W-1:0]       sq_root;

  // Saturating add of the product into the accumulator.
  assign sum = SW'(acc_q) + SW'(p_prod_q);
  assign ovf = (sum[SW-1:ACC_W-1] != {(SW-ACC_W+1){sum[SW-1]}});
  assign sat = ovf ? (sum[SW-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                   : sum[ACC_W-1:0];

  // A result item must wait for any root in flight so results stay in order.
  assign out_free  = !out_valid_q || out_ready_i;
  assign needs_out = (p_ctrl_q.kind == KIND_ELEM) || p_ctrl_q.last;
  assign p_go      = p_valid_q && (!needs_out ||
                     (!sq_stat.busy && ((p_ctrl_q.kind == KIND_ROOT) || out_free)));
  assign q_pop_o   = q_valid_i && (!p_valid_q || p_go);

  assign sq_start = p_go && (p_ctrl_q.kind == KIND_ROOT) && p_ctrl_q.last;
  assign radicand = sat[ACC_W-1] ? '0 : sat;
  assign sq_ack   = sq_stat.done && out_free;

  vdd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .ack_i      (sq_ack),
    .stat_o     (sq_stat),
    .root_o     (sq_root)
  );

  // Accumulator and output register next values.
  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    is_total_d  = is_total_q;
    if (p_go && (p_ctrl_q.kind != KIND_ELEM)) begin
      acc_d = p_ctrl_q.last ? '0 : sat;
    end
    if (sq_ack) begin
      out_valid_d = 1'b1;
      value_d     = ACC_W'(sq_root);
      is_total_d  = 1'b1;
    end else if (p_go && (p_ctrl_q.kind == KIND_ELEM)) begin
      out_valid_d = 1'b1;
      value_d     = ACC_W'(p_x_q);
      is_total_d  = 1'b0;
    end else if (p_go && (p_ctrl_q.kind == KIND_TOTAL) && p_ctrl_q.last) begin
      out_valid_d = 1'b1;
      value_d     = sat;
      is_total_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        p_valid_q <= 1'b1;
      end else if (p_go) begin
        p_valid_q <= 1'b0;
      end
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Multiply stage and output payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      p_ctrl_q <= q_ctrl_i;
      p_x_q    <= q_x_i;
      p_prod_q <= PW'(q_x_i) * PW'(q_y_i);
    end
    value_q    <= value_d;
    is_total_q <= is_total_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign is_total_o  = is_total_q;

endmodule

`default_nettype wire

// ===== test/vdd_result_checker.sv =====
// Result checker for the vector dot / distance unit testbench.
// Watches both channels, predicts every result and compares it field by field.
// Depends on vdd_pkg for the operation codes and port widths.
`timescale 1ns / 1ps

module vdd_result_checker #(
  parameter int unsigned ELEM_BITS = vdd_pkg::ELEM_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [2:0]                 op_i,
  input  logic [vdd_pkg::IN_W-1:0]   a_element_i,
  input  logic [vdd_pkg::IN_W-1:0]   b_element_i,
  input  logic                       last_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [vdd_pkg::ACC_W-1:0]  value_i,
  input  logic                       is_total_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                pending_o
);
  import vdd_pkg::*;

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             is_total;
  } result_t;

  // Saturation bounds of the 44-bit accumulator.
  localparam longint SUM_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  result_t due_results[$];
  longint  running_sum;

  // Takes the low ELEM_BITS bits of an element as two's complement.
  function automatic longint widen_elem(input logic [IN_W-1:0] x);
    logic [ELEM_BITS-1:0] low;
    low = ELEM_BITS'(x);
    return longint'($signed(low));
  endfunction

  // Floor square root, one result bit per pass; zero for totals not above zero.
  function automatic logic [ACC_W-1:0] floor_root(input longint x);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned probe;
    if (x <= 0) return '0;
    rem   = x;
    res   = 0;
    probe = longint'(1) << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res[ACC_W-1:0];
  endfunction

  // Advances the predicted accumulator by one item; returns 1 when the item
  // yields a result, which is then placed in res.
  function automatic bit sum_or_total(input logic [2:0] op, input logic [IN_W-1:0] a,
                                      input logic [IN_W-1:0] b, input logic last,
                                      output result_t res);
    longint av;
    longint bv;
    longint term;
    longint acc;
    av  = widen_elem(a);
    bv  = widen_elem(b);
    res = '0;
    case (op)
      OP_ADD: begin
        res.value = ACC_W'(av + bv);
        return 1'b1;
      end
      OP_SUB: begin
        res.value = ACC_W'(av - bv);
        return 1'b1;
      end
      OP_DOT:  term = av * bv;
      OP_NORM: term = av * av;
      OP_DIST, OP_SQDIST: term = (av - bv) * (av - bv);
      default: return 1'b0;
    endcase
    acc = running_sum + term;
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    running_sum = acc;
    if (!last) return 1'b0;
    // The op of the closing item decides between a root and a plain total.
    if (op == OP_NORM || op == OP_DIST) begin
      res.value = floor_root(running_sum);
    end else begin
      res.value = ACC_W'(running_sum);
    end
    res.is_total = 1'b1;
    running_sum  = 0;
    return 1'b1;
  endfunction

  // Predict on every input transfer, compare on every output transfer.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      due_results.delete();
      running_sum      = 0;
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (sum_or_total(op_i, a_element_i, b_element_i, last_i, want)) begin
          due_results.push_back(want);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: value %h, is_total %b", value_i, is_total_i);
          mismatch_count_o++;
        end else begin
          want = due_results.pop_front();
          if (value_i !== want.value) begin
            $error("value: expected %h, got %h", want.value, value_i);
            mismatch_count_o++;
          end
          if (is_total_i !== want.is_total) begin
            $error("is_total: expected %b, got %b", want.is_total, is_total_i);
            mismatch_count_o++;
          end
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== test/vector_dot_distance_unit_test.sv =====
// Top of the vector dot / distance unit testbench: clock, reset, stimulus and verdict.
// Depends on vdd_pkg, vector_dot_distance_unit and vdd_result_checker.
`timescale 1ns / 1ps

module vector_dot_distance_unit_test;
  import vdd_pkg::*;

  // Op codes that the unit takes and drops.
  localparam logic [2:0] OP_IGNORED_LO = 3'd6;
  localparam logic [2:0] OP_IGNORED_HI = 3'd7;

  // Notable Q8.8 element values.
  localparam logic [IN_W-1:0] ELEM_MAX = 16'h7fff;
  localparam logic [IN_W-1:0] ELEM_MIN = 16'h8000;
  localparam logic [IN_W-1:0] ELEM_ONE = 16'h0100;
  localparam logic [IN_W-1:0] ELEM_ZERO = 16'h0000;
  localparam logic [IN_W-1:0] ELEM_NEG_ONE = 16'hff00;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES  = 64;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_op;
  logic [IN_W-1:0]   in_a;
  logic [IN_W-1:0]   in_b;
  logic              in_last;
  logic              out_valid;
  logic              out_ready;
  logic [ACC_W-1:0]  out_value;
  logic              out_is_total;
  int unsigned       mismatch_count;
  int unsigned       pending_count;

  logic              hold_req;
  int unsigned       burst_left;
  int unsigned       scored_items;
  int unsigned       idle_cycles;

  vector_dot_distance_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (in_op),
    .a_element_i (in_a),
    .b_element_i (in_b),
    .last_i      (in_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .value_o     (out_value),
    .is_total_o  (out_is_total)
  );

  vdd_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (in_op),
    .a_element_i      (in_a),
    .b_element_i      (in_b),
    .last_i           (in_last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .value_i          (out_value),
    .is_total_i       (out_is_total),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Elements: extremes, small values around zero, or anything.
  function automatic logic [IN_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return ELEM_ZERO;
      3: return IN_W'($urandom_range(0, 1023)) - IN_W'(512);
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic op_e pick_reduction();
    case ($urandom_range(0, 3))
      0: return OP_DOT;
      1: return OP_NORM;
      2: return OP_DIST;
      default: return OP_SQDIST;
    endcase
  endfunction

  // Between bursts the sender drops valid for a random gap; some bursts run on.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Offers one item and waits for its transfer.
  task automatic push_element(input logic [2:0] op, input logic [IN_W-1:0] a,
                              input logic [IN_W-1:0] b, input logic last);
    in_valid <= 1'b1;
    in_op    <= op;
    in_a     <= a;
    in_b     <= b;
    in_last  <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (op <= OP_SQDIST) scored_items++;
    pace_sender();
  endtask

  // One reduction vector with random content, some mixed ops and some noise.
  task automatic send_vector(input op_e red_op, input int unsigned len);
    logic [2:0] op;
    for (int unsigned k = 0; k < len; k++) begin
      op = red_op;
      if ($urandom_range(0, 9) == 0) op = pick_reduction();
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: push_element(OP_IGNORED_LO, rand_elem(), rand_elem(), 1'($urandom_range(0, 1)));
          1: push_element(OP_IGNORED_HI, rand_elem(), rand_elem(), 1'($urandom_range(0, 1)));
          2: push_element(OP_ADD, rand_elem(), rand_elem(), 1'($urandom_range(0, 1)));
          default: push_element(OP_SUB, rand_elem(), rand_elem(), 1'($urandom_range(0, 1)));
        endcase
      end
      push_element(op, rand_elem(), rand_elem(), k == len - 1);
    end
  endtask

  // Stops offering until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    @(posedge clk_i);
  endtask

  // Receiver: segments of always-ready, random and patterned stalls, plus
  // the long hold-off that the sender asks for once.
  initial begin : receiver
    int unsigned seg_len;
    int unsigned mode;
    int unsigned phase;
    hold_req  = 1'b0;
    out_ready <= 1'b0;
    phase = 0;
    forever begin
      seg_len = $urandom_range(16, 160);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk_i);
        phase++;
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (phase % 8) < 5;
          endcase
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("vector_dot_distance_unit_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_goal;
    bit hold_done;
    bit drain_done;
    in_valid     <= 1'b0;
    in_op        <= OP_ADD;
    in_a         <= '0;
    in_b         <= '0;
    in_last      <= 1'b0;
    rst_ni       <= 1'b0;
    burst_left   = 0;
    scored_items = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Element ops at the extremes, with and without last.
    push_element(OP_ADD, ELEM_MAX, ELEM_MAX, 1'b0);
    push_element(OP_ADD, ELEM_MIN, ELEM_MIN, 1'b1);
    push_element(OP_SUB, ELEM_MAX, ELEM_MIN, 1'b0);
    push_element(OP_SUB, ELEM_MIN, ELEM_MAX, 1'b1);
    // Dot product with extreme products; a negative total.
    push_element(OP_DOT, ELEM_MAX, ELEM_MIN, 1'b0);
    push_element(OP_DOT, ELEM_MIN, ELEM_MIN, 1'b1);
    push_element(OP_DOT, ELEM_MIN, ELEM_MAX, 1'b1);
    // Norm and distance roots of the largest terms, then zero vectors.
    push_element(OP_NORM, ELEM_MIN, ELEM_ZERO, 1'b1);
    push_element(OP_DIST, ELEM_MAX, ELEM_MIN, 1'b1);
    push_element(OP_NORM, ELEM_ZERO, ELEM_MAX, 1'b1);
    push_element(OP_DOT, ELEM_ZERO, ELEM_ZERO, 1'b1);
    // Squared distance with an ignored op and an element op inside the vector.
    push_element(OP_SQDIST, ELEM_ONE, ELEM_NEG_ONE, 1'b0);
    push_element(OP_IGNORED_HI, ELEM_MAX, ELEM_ONE, 1'b1);
    push_element(OP_ADD, ELEM_ONE, ELEM_ONE, 1'b1);
    push_element(OP_IGNORED_LO, ELEM_MIN, ELEM_MAX, 1'b0);
    push_element(OP_SQDIST, ELEM_ZERO, ELEM_ONE, 1'b1);
    // Mixed ops: the closing op picks the kind of answer.
    push_element(OP_DOT, ELEM_ONE, ELEM_MAX, 1'b0);
    push_element(OP_NORM, ELEM_NEG_ONE, ELEM_ZERO, 1'b0);
    push_element(OP_DIST, ELEM_MAX, ELEM_ONE, 1'b1);
    // Negative total closed by a norm item: the root is zero.
    push_element(OP_DOT, ELEM_ONE, ELEM_NEG_ONE, 1'b0);
    push_element(OP_NORM, ELEM_ZERO, ELEM_ZERO, 1'b1);
    // A total of one unit and its root.
    push_element(OP_SQDIST, ELEM_ONE, ELEM_ZERO, 1'b1);
    push_element(OP_DIST, ELEM_ONE, ELEM_ZERO, 1'b1);
    drain_results();

    // Random phase: mostly well-formed vectors, some element ops and noise.
    random_goal = scored_items + RANDOM_ITEMS;
    while (scored_items < random_goal) begin
      if (!hold_done && scored_items + 1400 >= random_goal) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && scored_items + 700 >= random_goal) begin
        drain_results();
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          push_element($urandom_range(0, 1) ? OP_SUB : OP_ADD, rand_elem(), rand_elem(),
                       1'($urandom_range(0, 1)));
        end
      end else begin
        send_vector(pick_reduction(),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("vector_dot_distance_unit_test: clean");
    end else begin
      $display("vector_dot_distance_unit_test: errors");
    end
    $finish;
  end

endmodule
